/* sv/qppl_pkg.sv */
// Package for the quadrature position PI loop: register indexes, mode codes,
// step phase type and the saturation helpers used by the datapath.
// No dependencies; compiled before the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package qppl_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOOP_MODE  = 2'd0;
    localparam logic [1:0] REG_PROP_GAIN  = 2'd1;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd2;
    localparam logic [1:0] REG_STEP_SIZE  = 2'd3;

    // Loop mode codes. The unused code behaves as position mode.
    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;
    localparam logic [1:0] MODE_ANGULAR  = 2'd2;

    localparam int unsigned GAIN_W = 24;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 24'd1311;

    typedef enum logic [1:0] {
        PHASE_ZERO = 2'd0,
        PHASE_POS  = 2'd1,
        PHASE_NEG  = 2'd2
    } t_step_phase;

    // Saturate a 33-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] == v[31]) begin
            r = v[31:0];
        end else if (v[32]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Saturate a 58-bit signed value to 48 bits.
    function automatic logic signed [47:0] sat48(input logic signed [57:0] v);
        logic signed [47:0] r;
        if ((&v[57:47]) || (~|v[57:47])) begin
            r = v[47:0];
        end else if (v[57]) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = 48'sh7FFF_FFFF_FFFF;
        end
        return r;
    endfunction

    // Saturate a 32-bit signed difference to the 17-bit speed range.
    function automatic logic signed [16:0] sat17(input logic signed [31:0] v);
        logic signed [16:0] r;
        if ((&v[31:16]) || (~|v[31:16])) begin
            r = v[16:0];
        end else if (v[31]) begin
            r = 17'sh1_0000;
        end else begin
            r = 17'sh0_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/qppl_in_if.sv */
// Input channel of the quadrature position PI loop: valid/ready handshake
// carrying one counter sample. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface qppl_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] counter_value;
    logic        advance_setpoint;

    modport source (output valid, output counter_value, output advance_setpoint,
                    input ready);
    modport sink   (input valid, input counter_value, input advance_setpoint,
                    output ready);
endinterface

`default_nettype wire

/* sv/qppl_out_if.sv */
// Result channel of the quadrature position PI loop: valid/ready handshake
// carrying drive, position, speed and error. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface qppl_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] drive;
    logic signed [31:0] position;
    logic signed [16:0] speed;
    logic signed [31:0] error_value;

    modport source (output valid, output drive, output position, output speed,
                    output error_value, input ready);
    modport sink   (input valid, input drive, input position, input speed,
                    input error_value, output ready);
endinterface

`default_nettype wire

/* sv/quadrature_position_pi_loop.sv */
// Quadrature position PI loop: counter extension, setpoint sequencing and a
// five-stage PI datapath. Depends on qppl_pkg, qppl_in_if and qppl_out_if.
//
//  Channel  | Direction | Contents
//  ---------+-----------+----------------------------------------------
//  i_in     | in        | counter_value[15:0], advance_setpoint
//  o_out    | out       | drive[47:0], position[31:0], speed[16:0], error_value[31:0]
//  i_cfg_*  | in        | write enable, index[1:0], data[23:0]
//
// One sample is accepted per cycle unless output back-pressure stalls the pipe.
// Stages: position and setpoint, error, the two gain multipliers,
// integrator, drive. Each stage holds its item only while the one after it
// is full and stalled, so bubbles close up and input ready follows
// output ready through the stage valid flags. Synchronous reset clears the
// stage valids, the loop state and the registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_position_pi_loop
    import qppl_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [GAIN_W-1:0]  i_cfg_data,
    qppl_in_if.sink            i_in,
    qppl_out_if.source         o_out
);

    // Configuration registers.
    logic [1:0]        r_loop_mode;
    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [GAIN_W-1:0] r_step_size;

    // Loop state.
    logic [15:0]        r_last_counter;
    logic [15:0]        r_wrap_count;
    logic [31:0]        r_prev_position;
    logic signed [47:0] r_integrator;
    logic signed [31:0] r_target;
    logic signed [31:0] r_prev_pos_target;
    t_step_phase        r_step_phase;

    // Stage valids.
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic en_a, en_b, en_c, en_d, en_e;
    logic in_xfer;

    // Stage payloads.
    logic signed [31:0] r_a_pos, r_b_pos, r_c_pos, r_d_pos, r_e_pos;
    logic signed [16:0] r_a_spd, r_b_spd, r_c_spd, r_d_spd, r_e_spd;
    logic signed [31:0] r_a_setp;
    logic signed [31:0] r_b_err, r_c_err, r_d_err, r_e_err;
    logic signed [56:0] r_c_up, r_c_ip, r_d_up;
    logic signed [47:0] r_e_drive;

    // Next values of stage A and the loop state.
    logic signed [16:0] cnt_diff;
    logic [15:0]        n_wrap_count;
    logic [31:0]        n_pos_bits;
    logic signed [16:0] n_spd;
    logic signed [31:0] n_setp;
    logic [GAIN_W-1:0]  step_amp;
    logic signed [31:0] amp_ext;
    logic signed [31:0] n_target;
    t_step_phase        n_step_phase;

    logic signed [24:0] prop_s, integ_s;
    logic signed [56:0] n_c_up, n_c_ip;
    logic signed [47:0] n_integrator;

    assign en_e    = !r_e_valid || o_out.ready;
    assign en_d    = !r_d_valid || en_e;
    assign en_c    = !r_c_valid || en_d;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign in_xfer = i_in.valid && en_a;

    assign i_in.ready = en_a;

    always_comb begin
        cnt_diff     = $signed({1'b0, i_in.counter_value}) - $signed({1'b0, r_last_counter});
        n_wrap_count = r_wrap_count;
        // A forward jump of half the range is a wrap backwards, and vice versa.
        if (cnt_diff >= 17'sd32768) begin
            n_wrap_count = r_wrap_count - 16'd1;
        end else if (cnt_diff <= -17'sd32768) begin
            n_wrap_count = r_wrap_count + 16'd1;
        end
        n_pos_bits = {n_wrap_count, i_in.counter_value};
        n_spd      = sat17($signed(n_pos_bits - r_prev_position));

        if (r_loop_mode == MODE_VELOCITY) begin
            n_setp = sat32(33'(r_target) + 33'(r_prev_pos_target));
        end else begin
            n_setp = r_target;
        end

        if (r_loop_mode == MODE_ANGULAR) begin
            step_amp = r_step_size >> 1;
        end else begin
            step_amp = r_step_size;
        end
        amp_ext = $signed({8'd0, step_amp});

        case (r_step_phase)
            PHASE_POS: begin
                n_target     = amp_ext;
                n_step_phase = PHASE_NEG;
            end
            PHASE_NEG: begin
                n_target     = -amp_ext;
                n_step_phase = PHASE_ZERO;
            end
            default: begin
                n_target     = '0;
                n_step_phase = PHASE_POS;
            end
        endcase
    end

    assign prop_s  = $signed({1'b0, r_prop_gain});
    assign integ_s = $signed({1'b0, r_integ_gain});
    assign n_c_up  = prop_s * r_b_err;
    assign n_c_ip  = integ_s * r_b_err;
    assign n_integrator = sat48(58'(r_c_ip) + 58'(r_integrator));

    // Configuration and loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_mode       <= MODE_POSITION;
            r_prop_gain       <= PROP_GAIN_RESET;
            r_integ_gain      <= '0;
            r_step_size       <= '0;
            r_last_counter    <= '0;
            r_wrap_count      <= '0;
            r_prev_position   <= '0;
            r_integrator      <= '0;
            r_target          <= '0;
            r_prev_pos_target <= '0;
            r_step_phase      <= PHASE_ZERO;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LOOP_MODE:  r_loop_mode  <= i_cfg_data[1:0];
                    REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    REG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                    REG_STEP_SIZE:  r_step_size  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_last_counter    <= i_in.counter_value;
                r_wrap_count      <= n_wrap_count;
                r_prev_position   <= n_pos_bits;
                r_prev_pos_target <= n_setp;
                if (i_in.advance_setpoint) begin
                    r_target     <= n_target;
                    r_step_phase <= n_step_phase;
                end
            end
            // The integrator moves as each item enters the integrator stage.
            if (en_d && r_c_valid) begin
                r_integrator <= n_integrator;
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_in.valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
            if (en_d) r_d_valid <= r_c_valid;
            if (en_e) r_e_valid <= r_d_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_pos  <= $signed(n_pos_bits);
            r_a_spd  <= n_spd;
            r_a_setp <= n_setp;
        end
        if (en_b && r_a_valid) begin
            r_b_pos <= r_a_pos;
            r_b_spd <= r_a_spd;
            r_b_err <= sat32(33'(r_a_setp) - 33'(r_a_pos));
        end
        if (en_c && r_b_valid) begin
            r_c_pos <= r_b_pos;
            r_c_spd <= r_b_spd;
            r_c_err <= r_b_err;
            r_c_up  <= n_c_up;
            r_c_ip  <= n_c_ip;
        end
        if (en_d && r_c_valid) begin
            r_d_pos <= r_c_pos;
            r_d_spd <= r_c_spd;
            r_d_err <= r_c_err;
            r_d_up  <= r_c_up;
        end
        if (en_e && r_d_valid) begin
            r_e_pos   <= r_d_pos;
            r_e_spd   <= r_d_spd;
            r_e_err   <= r_d_err;
            r_e_drive <= sat48(58'(r_d_up) + 58'(r_integrator));
        end
    end

    assign o_out.valid       = r_e_valid;
    assign o_out.drive       = r_e_drive;
    assign o_out.position    = r_e_pos;
    assign o_out.speed       = r_e_spd;
    assign o_out.error_value = r_e_err;

endmodule

`default_nettype wire
